// ===== sv/tdps_pkg.sv =====
// Package for the trial-division primality tester.
// Holds the sequencer state type and the default operand width.
// No dependencies.
package tdps_pkg;

    // Default width of the tested value
    localparam int unsigned NUM_WIDTH_DEF = 32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BOUND,
        ST_DIV
    } state_t;

endpackage

// ===== sv/trial_division_prime_sqrt.sv =====
// Trial-division primality tester: top level.
// Depends on tdps_pkg (state type, default width).
//
// Usage:
//   Command channel: drive number and pulse start while busy is low; the item is
//   taken at that clock edge. busy stays high until the answer is out.
//   Result channel: done is high for exactly one cycle with is_prime valid in the
//   same cycle. The receiver cannot stall; the result must be captured then.
// Operation:
//   Divisors d = 2, 3, 4, ... are tried while d*d <= number. d*d is tracked
//   incrementally ((d+1)^2 = d^2 + 2d + 1), so no multiplier is needed.
//   Each divisor is checked by a shared restoring-division remainder unit that
//   consumes one bit of number per cycle.
//   Search stops at the first zero remainder (not prime) or when d*d > number
//   (prime). Zero and one are reported not prime right away.
// Timing: number < 2 is answered without a search; otherwise the run time is set
//   by the bit-serial remainder loop and grows with the divisors tried. One item
//   at a time. busy drops in the same cycle done is high, so the next start may follow.
// Reset: rst_n clears the sequencer to idle with no result pending.
module trial_division_prime_sqrt #(
    parameter int unsigned NUM_WIDTH = tdps_pkg::NUM_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [NUM_WIDTH-1:0] number,
    output logic                 done,
    output logic                 is_prime
);
    import tdps_pkg::*;

    // Divisor width: last divisor tried is at most 2^ceil(N/2)
    localparam int unsigned DW = (NUM_WIDTH + 1) / 2 + 1;
    // Square width: d^2 up to 2^(N+1)
    localparam int unsigned SW = NUM_WIDTH + 2;
    localparam int unsigned CW = $clog2(NUM_WIDTH);

    state_t                state_reg, state_next;
    logic [NUM_WIDTH-1:0]  value_reg, value_next;
    logic [DW-1:0]         div_reg, div_next;
    logic [SW-1:0]         sq_reg, sq_next;
    logic [DW-1:0]         rem_reg, rem_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  done_reg, done_next;
    logic                  prime_reg, prime_next;

    // Shared remainder step
    logic [DW:0]           rem_shift;
    logic [DW:0]           rem_diff;
    logic                  rem_ge;
    logic [DW-1:0]         rem_step;
    logic                  bound_over;
    logic                  accept;

    assign accept     = start && (state_reg == ST_IDLE);
    assign rem_shift  = {rem_reg, value_reg[cnt_reg]};
    assign rem_diff   = rem_shift - {1'b0, div_reg};
    assign rem_ge     = rem_shift >= {1'b0, div_reg};
    assign rem_step   = rem_ge ? rem_diff[DW-1:0] : rem_shift[DW-1:0];
    assign bound_over = sq_reg > {2'b00, value_reg};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && (number > NUM_WIDTH'(1)))
                begin
                    state_next = ST_BOUND;
                end
            end
            ST_BOUND:
            begin
                state_next = bound_over ? ST_IDLE : ST_DIV;
            end
            ST_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = (rem_step == '0) ? ST_IDLE : ST_BOUND;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and result
    always_comb
    begin
        value_next = value_reg;
        div_next   = div_reg;
        sq_next    = sq_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        prime_next = prime_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    value_next = number;
                    div_next   = DW'(2);
                    sq_next    = SW'(4);
                    if (number <= NUM_WIDTH'(1))
                    begin
                        done_next  = 1'b1;
                        prime_next = 1'b0;
                    end
                end
            end
            ST_BOUND:
            begin
                if (bound_over)
                begin
                    done_next  = 1'b1;
                    prime_next = 1'b1;
                end
                rem_next = '0;
                cnt_next = CW'(NUM_WIDTH - 1);
            end
            ST_DIV:
            begin
                rem_next = rem_step;
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == '0)
                begin
                    if (rem_step == '0)
                    begin
                        done_next  = 1'b1;
                        prime_next = 1'b0;
                    end
                    else
                    begin
                        // (d+1)^2 = d^2 + 2d + 1
                        sq_next  = sq_reg + SW'({div_reg, 1'b1});
                        div_next = div_reg + DW'(1);
                    end
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        div_reg   <= div_next;
        sq_reg    <= sq_next;
        rem_reg   <= rem_next;
        cnt_reg   <= cnt_next;
        prime_reg <= prime_next;
    end

    assign busy     = (state_reg != ST_IDLE);
    assign done     = done_reg;
    assign is_prime = prime_reg;

    // Result only appears once the sequencer is back to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == ST_IDLE))
        else $error("result strobe while busy");

    // A taken item either answers at once or starts the search
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (done_reg || (state_reg == ST_BOUND)))
        else $error("accepted item dropped");

    // A prime verdict only comes from the bound check
    a_prime_from_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && prime_reg) |-> ($past(state_reg) == ST_BOUND))
        else $error("prime reported outside bound check");

    // Divisor never drops below two during the search
    a_div_min: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (div_reg >= DW'(2)))
        else $error("divisor below two");

endmodule
